[design/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the clamped PID controller.
// ----------------------------------------------------------------------------
package pcc_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned GainWidth = 31;
   localparam int unsigned CsrIndexWidth = 3;

   // Integral sum limit: +/-50.0 in Q16.16
   localparam logic signed [DataWidth-1:0] IntegLimit = 32'sd3276800;

   // Reset limits: -1.0 and +1.0 in Q16.16
   localparam logic signed [DataWidth-1:0] DriveMinReset = -32'sd65536;
   localparam logic signed [DataWidth-1:0] DriveMaxReset = 32'sd65536;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_DERIV_GAIN = 3'd2,
      CSR_DRIVE_MIN  = 3'd3,
      CSR_DRIVE_MAX  = 3'd4
   } csr_index_type;

   typedef logic signed [DataWidth-1:0] q16_type;
   typedef logic [GainWidth-1:0] gain_type;

endpackage

[design/pcc_error.sv]
// ----------------------------------------------------------------------------
// pcc_error
// Saturated error and error difference stage; holds the previous error.
// ----------------------------------------------------------------------------
module pcc_error
   import pcc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  q16_type      target,
   input  q16_type      measured,
   output q16_type      err,
   output logic signed [DataWidth:0] delta
);

   logic signed [DataWidth:0] diff;
   q16_type                   err_in;
   q16_type                   err_ff;
   q16_type                   prev_err_ff;
   logic signed [DataWidth:0] delta_in;
   logic signed [DataWidth:0] delta_ff;

   always_comb begin
      diff = {target[DataWidth-1], target} - {measured[DataWidth-1], measured};
      // saturate on signed overflow of the difference
      if (diff[DataWidth] != diff[DataWidth-1]) begin
         err_in = diff[DataWidth] ? {1'b1, {(DataWidth-1){1'b0}}}
                                  : {1'b0, {(DataWidth-1){1'b1}}};
      end else begin
         err_in = diff[DataWidth-1:0];
      end
      delta_in = {err_in[DataWidth-1], err_in} - {prev_err_ff[DataWidth-1], prev_err_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
      end else if (load) begin
         prev_err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff   <= err_in;
         delta_ff <= delta_in;
      end
   end

   assign err   = err_ff;
   assign delta = delta_ff;

endmodule

[design/pcc_products.sv]
// ----------------------------------------------------------------------------
// pcc_products
// Gain products, floored back to Q16.16 by dropping the low 16 bits.
// ----------------------------------------------------------------------------
module pcc_products
   import pcc_pkg::*;
(
   input  logic                         clock,
   input  logic                         load,
   input  q16_type                      err,
   input  logic signed [DataWidth:0]    delta,
   input  gain_type                     prop_gain,
   input  gain_type                     integ_gain,
   input  gain_type                     deriv_gain,
   output logic signed [47:0]           p_term,
   output logic signed [47:0]           i_term,
   output logic signed [48:0]           d_term
);

   logic signed [63:0] p_prod;
   logic signed [63:0] i_prod;
   logic signed [64:0] d_prod;
   logic signed [47:0] p_ff;
   logic signed [47:0] i_ff;
   logic signed [48:0] d_ff;

   always_comb begin
      p_prod = $signed({1'b0, prop_gain}) * err;
      i_prod = $signed({1'b0, integ_gain}) * err;
      d_prod = $signed({1'b0, deriv_gain}) * delta;
   end

   // upper bits of a two's complement product are the floor of prod / 2^16
   always_ff @(posedge clock) begin
      if (load) begin
         p_ff <= p_prod[63:16];
         i_ff <= i_prod[63:16];
         d_ff <= d_prod[64:16];
      end
   end

   assign p_term = p_ff;
   assign i_term = i_ff;
   assign d_term = d_ff;

endmodule

[design/pcc_integrator.sv]
// ----------------------------------------------------------------------------
// pcc_integrator
// Clamped integral accumulator and proportional plus derivative sum.
// ----------------------------------------------------------------------------
module pcc_integrator
   import pcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic signed [47:0]  p_term,
   input  logic signed [47:0]  i_term,
   input  logic signed [48:0]  d_term,
   output q16_type             sum,
   output logic signed [49:0]  pd_sum
);

   localparam logic signed [48:0] SumHigh = 49'(IntegLimit);
   localparam logic signed [48:0] SumLow  = -49'(IntegLimit);

   logic signed [48:0] sum_raw;
   q16_type            sum_in;
   q16_type            sum_ff;
   logic signed [49:0] pd_in;
   logic signed [49:0] pd_ff;

   always_comb begin
      sum_raw = 49'(sum_ff) + 49'(i_term);
      if (sum_raw < SumLow) begin
         sum_in = SumLow[DataWidth-1:0];
      end else if (sum_raw > SumHigh) begin
         sum_in = SumHigh[DataWidth-1:0];
      end else begin
         sum_in = sum_raw[DataWidth-1:0];
      end
      pd_in = 50'(p_term) + 50'(d_term);
   end

   // the sum register doubles as this stage's payload for the item
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (load) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pd_ff <= pd_in;
      end
   end

   assign sum    = sum_ff;
   assign pd_sum = pd_ff;

endmodule

[design/pcc_output.sv]
// ----------------------------------------------------------------------------
// pcc_output
// Final sum and output limit clamp into the result register.
// ----------------------------------------------------------------------------
module pcc_output
   import pcc_pkg::*;
(
   input  logic                clock,
   input  logic                load,
   input  logic signed [49:0]  pd_sum,
   input  q16_type             sum,
   input  q16_type             drive_min,
   input  q16_type             drive_max,
   output q16_type             drive
);

   logic signed [50:0] total;
   logic signed [50:0] lim_lo;
   logic signed [50:0] lim_hi;
   q16_type            drive_in;
   q16_type            drive_ff;

   always_comb begin
      total  = 51'(pd_sum) + 51'(sum);
      lim_lo = 51'(drive_min);
      lim_hi = 51'(drive_max);
      // crossed limits: drive_min for totals under it, drive_max for all others
      if (total < lim_lo) begin
         drive_in = drive_min;
      end else if (total > lim_hi) begin
         drive_in = drive_max;
      end else begin
         drive_in = total[DataWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff <= drive_in;
      end
   end

   assign drive = drive_ff;

endmodule

[design/pid_controller_clamped_top.sv]
// ----------------------------------------------------------------------------
// pid_controller_clamped_top
// Clamped discrete PID controller, signed Q16.16, five-stage pipeline.
// ----------------------------------------------------------------------------
// Each request word carries a setpoint and a measurement; each response word
// carries one drive value. The block takes a new word every cycle while the
// response side does not stall; each word passes through the input register,
// error stage, multiplier stage, integrator stage and output register. The
// sustained rate of one word per cycle is held because the only feedback paths,
// the stored previous error and the integral sum, each close within a single
// stage. Stalls ripple back stage by stage, so empty stages keep filling while a
// finished response waits. Gains and limits are written through the csr port,
// only while the block is idle: a rule on the user, not enforced by the block.
// Writing the limits does not re-clamp the integral.
module pid_controller_clamped_top
   import pcc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_target,
   input  logic signed [31:0]        req_measured,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [31:0]        rsp_drive,
   // configuration write port
   input  logic                      csr_write_enable,
   input  logic [CsrIndexWidth-1:0]  csr_index,
   input  logic [DataWidth-1:0]      csr_write_data
);

   localparam int unsigned Stages = 5;

   // configuration registers
   gain_type prop_gain_ff;
   gain_type integ_gain_ff;
   gain_type deriv_gain_ff;
   q16_type  drive_min_ff;
   q16_type  drive_max_ff;

   // pipeline control
   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic [Stages-1:0] ready;
   logic [Stages-1:0] load;

   // input register
   q16_type target_ff;
   q16_type measured_ff;

   // stage payloads
   q16_type            err;
   logic signed [32:0] delta;
   logic signed [47:0] p_term;
   logic signed [47:0] i_term;
   logic signed [48:0] d_term;
   q16_type            sum;
   logic signed [49:0] pd_sum;

   // decode register writes; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         drive_min_ff  <= DriveMinReset;
         drive_max_ff  <= DriveMaxReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_write_data[GainWidth-1:0];
            CSR_INTEG_GAIN: integ_gain_ff <= csr_write_data[GainWidth-1:0];
            CSR_DERIV_GAIN: deriv_gain_ff <= csr_write_data[GainWidth-1:0];
            CSR_DRIVE_MIN:  drive_min_ff  <= csr_write_data;
            CSR_DRIVE_MAX:  drive_max_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // a stage takes a word when empty or when its word moves on this cycle
   always_comb begin
      ready[Stages-1] = !valid_ff[Stages-1] || rsp_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      load[0] = req_valid && ready[0];
      for (int k = 1; k < Stages; k++) begin
         load[k] = valid_ff[k-1] && ready[k];
      end
      for (int k = 0; k < Stages - 1; k++) begin
         valid_in[k] = load[k] || (valid_ff[k] && !ready[k+1]);
      end
      valid_in[Stages-1] = load[Stages-1] || (valid_ff[Stages-1] && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture the request word
   always_ff @(posedge clock) begin
      if (load[0]) begin
         target_ff   <= req_target;
         measured_ff <= req_measured;
      end
   end

   pcc_error u_error (
      .clock    (clock),
      .reset    (reset),
      .load     (load[1]),
      .target   (target_ff),
      .measured (measured_ff),
      .err      (err),
      .delta    (delta)
   );

   pcc_products u_products (
      .clock      (clock),
      .load       (load[2]),
      .err        (err),
      .delta      (delta),
      .prop_gain  (prop_gain_ff),
      .integ_gain (integ_gain_ff),
      .deriv_gain (deriv_gain_ff),
      .p_term     (p_term),
      .i_term     (i_term),
      .d_term     (d_term)
   );

   pcc_integrator u_integrator (
      .clock  (clock),
      .reset  (reset),
      .load   (load[3]),
      .p_term (p_term),
      .i_term (i_term),
      .d_term (d_term),
      .sum    (sum),
      .pd_sum (pd_sum)
   );

   pcc_output u_output (
      .clock     (clock),
      .load      (load[4]),
      .pd_sum    (pd_sum),
      .sum       (sum),
      .drive_min (drive_min_ff),
      .drive_max (drive_max_ff),
      .drive     (rsp_drive)
   );

   assign req_ready = ready[0];
   assign rsp_valid = valid_ff[Stages-1];

endmodule

[design/pcc_checker.sv]
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pcc_checker
   import pcc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_drive
);

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("response word dropped or changed while stalled");

   // drop all words on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an empty output means nothing blocks the request side
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled with empty output");

   // a word needs at least the pipeline depth to come out of an empty block
   a_no_early_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("response appeared sooner than the pipeline depth");

endmodule

bind pid_controller_clamped_top pcc_checker u_pcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_drive (rsp_drive)
);
